### hdl/knnwm_pkg.sv
// knnwm_pkg: shared types, widths and fill-method codes for the
// neighbour-mean imputer. No dependencies.
package knnwm_pkg;

  localparam int VALUE_BITS          = 16;
  localparam int WEIGHT_BITS         = 16;
  localparam int DEF_MAX_NEIGHBOURS  = 64;

  // fill_method codes
  localparam logic [1:0] FILL_WEIGHTED = 2'd0;
  localparam logic [1:0] FILL_PLAIN    = 2'd1;
  localparam logic [1:0] FILL_COLUMN   = 2'd2;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  neighbour_value;
    logic                          neighbour_missing;
    logic                          index_in_range;
    logic signed [WEIGHT_BITS-1:0] similarity_weight;
    logic signed [VALUE_BITS-1:0]  fallback_mean;
    logic                          last_neighbour;
  } neighbour_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] imputed_value;
    logic [1:0]                   fill_method;
  } result_t;

endpackage

### hdl/knnwm_front.sv
// knnwm_front: accepts neighbour items, accumulates the totals and, on the
// last item, forms one division job. Depends on knnwm_pkg.
module knnwm_front import knnwm_pkg::*; #(
  parameter  int MAX_NEIGHBOURS = DEF_MAX_NEIGHBOURS,
  localparam int CB  = $clog2(MAX_NEIGHBOURS + 1),
  localparam int WTW = WEIGHT_BITS - 1 + CB,
  localparam int WVW = VALUE_BITS + WEIGHT_BITS + CB,
  localparam int VTW = VALUE_BITS + CB
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  neighbour_t                   neighbour,
  output logic                         job_push,
  input  logic                         job_full,
  output logic [1:0]                   job_method,
  output logic signed [WVW-1:0]        job_dividend,
  output logic [WTW-1:0]               job_divisor,
  output logic signed [VALUE_BITS-1:0] job_fallback
);

  logic                                   pending;
  logic [WTW-1:0]                         weight_total;
  logic signed [WVW-1:0]                  weighted_value_total;
  logic signed [VTW-1:0]                  value_total;
  logic [CB-1:0]                          valid_count;
  logic signed [VALUE_BITS-1:0]           fallback;

  logic                                   take;
  logic                                   counts;
  logic [WEIGHT_BITS-2:0]                 w_clamp;
  logic signed [VALUE_BITS+WEIGHT_BITS-1:0] prod;

  assign take   = push && !pending;
  assign full   = pending;
  assign counts = neighbour.index_in_range && !neighbour.neighbour_missing &&
                  (valid_count < CB'(MAX_NEIGHBOURS));
  // negative weights count as zero
  assign w_clamp = neighbour.similarity_weight[WEIGHT_BITS-1] ? '0 :
                   neighbour.similarity_weight[WEIGHT_BITS-2:0];
  assign prod    = neighbour.neighbour_value * $signed({1'b0, w_clamp});

  always_ff @(posedge clk) begin
    if (rst) begin
      pending              <= 1'b0;
      weight_total         <= '0;
      weighted_value_total <= '0;
      value_total          <= '0;
      valid_count          <= '0;
    end else if (pending) begin
      if (!job_full) begin
        pending              <= 1'b0;
        weight_total         <= '0;
        weighted_value_total <= '0;
        value_total          <= '0;
        valid_count          <= '0;
      end
    end else if (take) begin
      if (counts) begin
        weight_total         <= weight_total + WTW'(w_clamp);
        weighted_value_total <= weighted_value_total +
                                {{CB{prod[VALUE_BITS+WEIGHT_BITS-1]}}, prod};
        value_total          <= value_total +
                                {{CB{neighbour.neighbour_value[VALUE_BITS-1]}},
                                 neighbour.neighbour_value};
        valid_count          <= valid_count + 1'b1;
      end
      if (neighbour.last_neighbour) begin
        pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && neighbour.last_neighbour) begin
      fallback <= neighbour.fallback_mean;
    end
  end

  // job selection from the settled totals
  assign job_push     = pending;
  assign job_fallback = fallback;

  always_comb begin
    if (valid_count == '0) begin
      job_method   = FILL_COLUMN;
      job_dividend = '0;
      job_divisor  = '0;
    end else if (weight_total != '0) begin
      job_method   = FILL_WEIGHTED;
      job_dividend = weighted_value_total;
      job_divisor  = weight_total;
    end else begin
      job_method   = FILL_PLAIN;
      job_dividend = {{(WVW-VTW){value_total[VTW-1]}}, value_total};
      job_divisor  = {{(WTW-CB){1'b0}}, valid_count};
    end
  end

endmodule

### hdl/knnwm_jobq.sv
// knnwm_jobq: two-entry job queue between the accumulator and the divider.
// Depends on knnwm_pkg (import only for house consistency of widths).
module knnwm_jobq import knnwm_pkg::*; #(
  parameter int WIDTH = 2 * VALUE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      if (do_push && !do_pop)      fill <= fill + 2'd1;
      else if (do_pop && !do_push) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

### hdl/knnwm_back.sv
// knnwm_back: bit-serial signed divider with saturation and the result
// register. Depends on knnwm_pkg.
module knnwm_back import knnwm_pkg::*; #(
  parameter  int MAX_NEIGHBOURS = DEF_MAX_NEIGHBOURS,
  localparam int CB  = $clog2(MAX_NEIGHBOURS + 1),
  localparam int WTW = WEIGHT_BITS - 1 + CB,
  localparam int WVW = VALUE_BITS + WEIGHT_BITS + CB,
  localparam int SW  = $clog2(WVW + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_empty,
  output logic                         job_pop,
  input  logic [1:0]                   job_method,
  input  logic signed [WVW-1:0]        job_dividend,
  input  logic [WTW-1:0]               job_divisor,
  input  logic signed [VALUE_BITS-1:0] job_fallback,
  output logic                         empty,
  input  logic                         pop,
  output result_t                      result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [WVW-1:0] POS_LIM = {{(WVW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic [WVW-1:0] NEG_LIM = POS_LIM + 1'b1;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [1:0]                   method;
  logic                         neg;
  logic [WVW-1:0]               quot;
  logic [WTW-1:0]               rem;
  logic [WTW-1:0]               divisor;
  logic [SW-1:0]                steps;
  logic signed [VALUE_BITS-1:0] fallback;
  logic                         out_valid;

  logic [WTW:0]                 trial;
  logic [WTW:0]                 diff;
  logic                         ge;
  logic [WVW-1:0]               mag;
  logic [WVW-1:0]               neg_q;
  logic [VALUE_BITS-1:0]        sat_value;
  logic                         out_free;

  assign trial    = {rem, quot[WVW-1]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = (trial >= {1'b0, divisor});
  assign mag      = job_dividend[WVW-1] ? (~job_dividend + 1'b1) : job_dividend;
  assign neg_q    = ~quot + 1'b1;
  assign out_free = !out_valid || pop;
  assign job_pop  = (state == ST_IDLE) && !job_empty;
  assign empty    = !out_valid;

  always_comb begin
    if (method == FILL_COLUMN) begin
      sat_value = fallback;
    end else if (neg) begin
      sat_value = (quot > NEG_LIM) ? NEG_LIM[VALUE_BITS-1:0] : neg_q[VALUE_BITS-1:0];
    end else begin
      sat_value = (quot > POS_LIM) ? POS_LIM[VALUE_BITS-1:0] : quot[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!job_empty) state_next = (job_method == FILL_COLUMN) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (steps == SW'(1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (pop)                     out_valid <= 1'b0;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!job_empty) begin
          method   <= job_method;
          neg      <= job_dividend[WVW-1];
          quot     <= mag;
          rem      <= '0;
          divisor  <= job_divisor;
          steps    <= SW'(WVW);
          fallback <= job_fallback;
        end
      end
      ST_DIV: begin
        quot  <= {quot[WVW-2:0], ge};
        rem   <= ge ? diff[WTW-1:0] : trial[WTW-1:0];
        steps <= steps - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          result.imputed_value <= sat_value;
          result.fill_method   <= method;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/knn_weighted_mean_imputer.sv
// knn_weighted_mean_imputer: top level; accumulator front, job queue and
// serial divider back. Depends on knnwm_pkg, knnwm_front, knnwm_jobq, knnwm_back.
//
//  channel   handshake     payload        role
//  neighbour push / full   neighbour_t    one item per neighbour of a missing entry
//  result    empty / pop   result_t       one filled value per last item
//
// A last item raises full in the cycle after it is taken, while its job is
// handed to the queue; full stays high for as long as the queue is full.
// Each weighted or plain mean goes through the serial divider, which takes a
// new job only when it is idle; the column-mean case skips the divider.
// The divider sets the rate per entry.
// rst is synchronous: it clears the totals, the queue and the result valid flag.
// The result register holds while pop is low; the divider finishes its entry and
// waits, while the front keeps working until the two-entry job queue fills.
module knn_weighted_mean_imputer import knnwm_pkg::*; #(
  parameter int MAX_NEIGHBOURS = DEF_MAX_NEIGHBOURS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  neighbour_t neighbour,
  output logic       empty,
  input  logic       pop,
  output result_t    result
);

  localparam int CB  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int WTW = WEIGHT_BITS - 1 + CB;
  localparam int WVW = VALUE_BITS + WEIGHT_BITS + CB;
  localparam int JW  = 2 + WVW + WTW + VALUE_BITS;

  // front -> queue
  logic                         f_push;
  logic                         f_full;
  logic [1:0]                   f_method;
  logic signed [WVW-1:0]        f_dividend;
  logic [WTW-1:0]               f_divisor;
  logic signed [VALUE_BITS-1:0] f_fallback;

  // queue -> back
  logic                         q_empty;
  logic                         q_pop;
  logic [JW-1:0]                q_dout;
  logic [1:0]                   b_method;
  logic signed [WVW-1:0]        b_dividend;
  logic [WTW-1:0]               b_divisor;
  logic signed [VALUE_BITS-1:0] b_fallback;

  knnwm_front #(.MAX_NEIGHBOURS(MAX_NEIGHBOURS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .neighbour    (neighbour),
    .job_push     (f_push),
    .job_full     (f_full),
    .job_method   (f_method),
    .job_dividend (f_dividend),
    .job_divisor  (f_divisor),
    .job_fallback (f_fallback)
  );

  knnwm_jobq #(.WIDTH(JW)) u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   ({f_method, f_dividend, f_divisor, f_fallback}),
    .full  (f_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {b_method, b_dividend, b_divisor, b_fallback} = q_dout;

  knnwm_back #(.MAX_NEIGHBOURS(MAX_NEIGHBOURS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_empty    (q_empty),
    .job_pop      (q_pop),
    .job_method   (b_method),
    .job_dividend (b_dividend),
    .job_divisor  (b_divisor),
    .job_fallback (b_fallback),
    .empty        (empty),
    .pop          (pop),
    .result       (result)
  );

endmodule

### hdl/knnwm_checker.sv
// knnwm_checker: port-level assertions for the imputer, bound to the top.
// Depends on knnwm_pkg and knn_weighted_mean_imputer.
module knnwm_checker import knnwm_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input neighbour_t neighbour,
  input logic       empty,
  input logic       pop,
  input result_t    result
);

  // reset leaves nothing waiting and the input open
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("state not cleared by reset");

  // a last item closes the entry, so the next cycle is busy
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    push && !full && neighbour.last_neighbour |=> full)
    else $error("last item not followed by job handoff");

  // ordinary items never stall the input
  a_plain_open: assert property (@(posedge clk) disable iff (rst)
    push && !full && !neighbour.last_neighbour |=> !full)
    else $error("input stalled after a non-last item");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed or dropped");

endmodule

bind knn_weighted_mean_imputer knnwm_checker u_checker (.*);

### verif/knn_weighted_mean_imputer_tb.sv
`timescale 1ns / 1ps
// knn_weighted_mean_imputer_tb: self-checking bench for the neighbour-mean imputer.
// Depends on knnwm_pkg and knn_weighted_mean_imputer; a local predictor tracks the totals.
module knn_weighted_mean_imputer_tb;
  import knnwm_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The limit
  // covers one entry through the divider, the longest sender gap, the longest
  // result stall, a full two-entry job queue, and margin.
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 120;
  localparam int RANDOM_ITEMS  = 1050;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  neighbour_t neighbour = '0;
  logic       empty;
  logic       pop = 1'b0;
  result_t    result;

  knn_weighted_mean_imputer u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .neighbour (neighbour),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Running totals of the entry in progress, at least as wide as the block's totals.
  logic [21:0]        weight_sum;
  logic signed [39:0] weighted_sum;
  logic signed [23:0] value_sum;
  logic [6:0]         valid_neighbours;

  result_t expected_fills[$];

  int  mismatches   = 0;
  int  items_sent   = 0;
  int  idle_cycles  = 0;
  int  stall_left   = 0;
  bit  steady_src   = 1'b0;   // sender never idles
  bit  steady_sink  = 1'b0;   // receiver never stalls

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic logic signed [VALUE_BITS-1:0] clip_value(input longint q);
    if (q > 32767) begin
      return 16'sh7fff;
    end
    if (q < -32768) begin
      return 16'sh8000;
    end
    return q[VALUE_BITS-1:0];
  endfunction

  // Fold one accepted item into the totals; a last item closes the entry and
  // queues the fill it must produce.
  function automatic void predict_fill(input neighbour_t n);
    logic signed [WEIGHT_BITS-1:0] w;
    longint                        num;
    longint                        den;
    result_t                       fill;
    if (n.index_in_range && !n.neighbour_missing &&
        int'(valid_neighbours) < DEF_MAX_NEIGHBOURS) begin
      // negative similarity counts as no weight at all
      w = ($signed(n.similarity_weight) < 0) ? '0 : n.similarity_weight;
      weight_sum   = weight_sum + {6'b0, w};
      weighted_sum = weighted_sum +
                     40'(longint'($signed(w)) * longint'($signed(n.neighbour_value)));
      value_sum    = value_sum + 24'(longint'($signed(n.neighbour_value)));
      valid_neighbours++;
    end
    if (!n.last_neighbour) begin
      return;
    end
    if (valid_neighbours == 0) begin
      fill.imputed_value = n.fallback_mean;
      fill.fill_method   = FILL_COLUMN;
    end else if (weight_sum != 0) begin
      num = longint'($signed(weighted_sum));
      den = longint'({42'b0, weight_sum});
      fill.imputed_value = clip_value(num / den);   // truncates toward zero
      fill.fill_method   = FILL_WEIGHTED;
    end else begin
      num = longint'($signed(value_sum));
      den = longint'({57'b0, valid_neighbours});
      fill.imputed_value = clip_value(num / den);
      fill.fill_method   = FILL_PLAIN;
    end
    expected_fills.push_back(fill);
    weight_sum       = '0;
    weighted_sum     = '0;
    value_sum        = '0;
    valid_neighbours = '0;
  endfunction

  function automatic neighbour_t make_neighbour(input int v, input int w, input bit miss,
                                                input bit in_range, input int fb,
                                                input bit last);
    neighbour_t n;
    n.neighbour_value   = 16'(v);
    n.similarity_weight = 16'(w);
    n.neighbour_missing = miss;
    n.index_in_range    = in_range;
    n.fallback_mean     = 16'(fb);
    n.last_neighbour    = last;
    return n;
  endfunction

  // Called at a rising edge. push stays high through back-to-back items and is
  // only dropped when a gap follows, so it never gets two updates in one step.
  task automatic send_neighbour(input neighbour_t n);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_src || r < 65) begin
      gap = 0;
    end else if (r < 94) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    neighbour <= n;
    @(posedge clk);
    while (full) @(posedge clk);
    // accepted at this edge
    predict_fill(n);
    items_sent++;
  endtask

  function automatic neighbour_t random_neighbour(input bit last, input int unsigned wmode,
                                                  input int unsigned vmode,
                                                  input int unsigned miss_pct);
    neighbour_t  n;
    int unsigned pick;
    n.neighbour_missing = ($urandom_range(0, 99) < miss_pct);
    n.index_in_range    = ($urandom_range(0, 99) >= 8);
    n.fallback_mean     = 16'($urandom);
    n.last_neighbour    = last;
    case (vmode)
      0: n.neighbour_value = 16'($urandom);
      1: n.neighbour_value = 16'(int'($urandom_range(0, 16383)) - 8192);
      default: begin
        pick = $urandom_range(0, 4);
        n.neighbour_value = (pick == 0) ? 16'sh7fff :
                            (pick == 1) ? 16'sh8000 :
                            (pick == 2) ? 16'sh0000 :
                            (pick == 3) ? 16'shffff : 16'sh0001;
      end
    endcase
    case (wmode)
      0: n.similarity_weight = 16'($urandom);
      1: n.similarity_weight = {1'b0, 15'($urandom)};
      default: begin
        // nothing positive: forces the plain mean
        n.similarity_weight = ($urandom_range(0, 99) < 30) ? 16'h0000 :
                              {1'b1, 15'($urandom)};
      end
    endcase
    return n;
  endfunction

  // Each fill method, extremes, truncation of negative quotients and skipped
  // last items.
  task automatic test_directed();
    send_neighbour(make_neighbour(4096, 8192, 0, 1, 0, 1));
    send_neighbour(make_neighbour(32767, 32767, 0, 1, 0, 1));
    send_neighbour(make_neighbour(-32768, 32767, 0, 1, 0, 1));
    // all weights zero or negative -> plain mean
    send_neighbour(make_neighbour(-32768, -32768, 0, 1, 0, 0));
    send_neighbour(make_neighbour(32767, 0, 0, 1, 0, 1));
    send_neighbour(make_neighbour(-1, 0, 0, 1, 0, 0));
    send_neighbour(make_neighbour(-2, -5, 0, 1, 0, 1));
    // weighted quotient of -4096.5 truncates toward zero
    send_neighbour(make_neighbour(-4097, 1, 0, 1, 0, 0));
    send_neighbour(make_neighbour(-4096, 1, 0, 1, 0, 1));
    // no valid neighbour -> column mean passes through
    send_neighbour(make_neighbour(100, 16384, 1, 1, -32768, 1));
    send_neighbour(make_neighbour(100, 16384, 0, 0, 32767, 1));
    send_neighbour(make_neighbour(-32768, -32768, 1, 0, -1, 1));
    // skipped last item still closes an entry with valid neighbours
    send_neighbour(make_neighbour(8192, 16384, 0, 1, 0, 0));
    send_neighbour(make_neighbour(0, 0, 1, 0, 12345, 1));
    // mixed weights, including a negative one on a missing item
    send_neighbour(make_neighbour(1000, 300, 0, 1, 0, 0));
    send_neighbour(make_neighbour(-3000, 700, 0, 1, 0, 0));
    send_neighbour(make_neighbour(0, -1, 1, 1, 0, 0));
    send_neighbour(make_neighbour(2000, 16000, 0, 1, 0, 1));
    // one weight of 1 against large values
    send_neighbour(make_neighbour(-32768, 1, 0, 1, 0, 0));
    send_neighbour(make_neighbour(-32768, 0, 0, 1, 0, 1));
  endtask

  // More valid neighbours than the block keeps: the extras must be dropped.
  task automatic test_neighbour_limit();
    for (int i = 0; i < 70; i++) begin
      send_neighbour(random_neighbour(1'b0, i % 2, 2, 0));
    end
    send_neighbour(make_neighbour(32767, 32767, 0, 1, 0, 1));
    // exactly the limit, then a missing last item
    for (int i = 0; i < DEF_MAX_NEIGHBOURS; i++) begin
      send_neighbour(make_neighbour(-32768, 32767, 0, 1, 0, 0));
    end
    send_neighbour(make_neighbour(0, 0, 1, 1, 777, 1));
    // limit with no positive weight -> plain mean at the extreme
    for (int i = 0; i < 66; i++) begin
      send_neighbour(make_neighbour(32767, -1, 0, 1, 0, 0));
    end
    send_neighbour(make_neighbour(0, 0, 0, 0, 0, 1));
  endtask

  // Whole entries of random length and content; pacing mode changes now and then.
  task automatic test_random_entries();
    int unsigned len;
    int unsigned r;
    int unsigned wmode;
    int unsigned vmode;
    int unsigned miss_pct;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      len = (r < 85) ? $urandom_range(1, 12) :
            (r < 97) ? $urandom_range(13, 40) : $urandom_range(60, 75);
      wmode    = $urandom_range(0, 2);
      vmode    = $urandom_range(0, 2);
      miss_pct = ($urandom_range(0, 9) == 0) ? 90 : 15;
      if ($urandom_range(0, 9) == 0) begin
        steady_src  = $urandom_range(0, 1);
        steady_sink = $urandom_range(0, 1);
      end
      for (int unsigned i = 1; i <= len; i++) begin
        send_neighbour(random_neighbour(i == len, wmode, vmode, miss_pct));
      end
    end
    steady_src  = 1'b0;
    steady_sink = 1'b0;
  endtask

  // Result side: check whatever was taken at this edge, then pick the next pop.
  always @(posedge clk) begin
    result_t exp_fill;
    int unsigned r;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_fills.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d method=%0d",
                                    $signed(result.imputed_value), result.fill_method));
        end else begin
          exp_fill = expected_fills.pop_front();
          if (result.imputed_value !== exp_fill.imputed_value) begin
            report_mismatch($sformatf("imputed_value %0d, expected %0d",
                                      $signed(result.imputed_value),
                                      $signed(exp_fill.imputed_value)));
          end
          if (result.fill_method !== exp_fill.fill_method) begin
            report_mismatch($sformatf("fill_method %0d, expected %0d",
                                      result.fill_method, exp_fill.fill_method));
          end
        end
      end
      r = $urandom_range(0, 99);
      if (steady_sink) begin
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        pop <= 1'b0;
      end else if (r < 60) begin
        pop <= 1'b1;
      end else if (r < 95) begin
        stall_left <= $urandom_range(0, 3);
        pop <= 1'b0;
      end else begin
        stall_left <= $urandom_range(10, 60);
        pop <= 1'b0;
      end
    end
  end

  // Watchdog: any accepted item on either side restarts the count.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    weight_sum       = '0;
    weighted_sum     = '0;
    value_sum        = '0;
    valid_neighbours = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_neighbour_limit();
    test_random_entries();
    push <= 1'b0;
    while (expected_fills.size() != 0) @(posedge clk);
    // let any stray result surface before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_fills.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
